### rtl/tcspq_pkg.sv
`default_nettype none

package tcspq_pkg;

   localparam int FUNC_BITS   = 2;
   localparam int KEY_BITS    = 7;
   localparam int EXT_TAG_BITS = 16;
   localparam int STATUS_BITS = 3;

   localparam logic [FUNC_BITS-1:0] FUNC_ADD   = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_SERVE = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_LIST  = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_ADDED  = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_SERVED = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_NONE   = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_LIST   = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY  = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_FULL   = 3'd5;

   localparam logic QSEL_NORMAL   = 1'b0;
   localparam logic QSEL_PRIORITY = 1'b1;

   localparam logic [KEY_BITS-1:0] THRESHOLD_RESET = 7'd60;

   // Register index decoded from paddr[2]
   localparam logic REG_THRESHOLD = 1'b0;

   // Per-cell load select, worked out by the chain
   typedef struct packed {
      logic load_new;
      logic take_nbr;
      logic take_head;
   } cell_ctrl_type;

   // Per-queue command from the sequencer
   typedef struct packed {
      logic push;
      logic pop;
      logic rotate;
   } chain_cmd_type;

endpackage

`default_nettype wire

### rtl/tcspq_cell.sv
`default_nettype none

module tcspq_cell
   import tcspq_pkg::*;
#(
   parameter int WIDTH = 16
) (
   input  wire logic                 clock,
   input  wire cell_ctrl_type        ctrl,
   input  wire logic [WIDTH-1:0]     new_data,
   input  wire logic [WIDTH-1:0]     nbr_data,
   input  wire logic [WIDTH-1:0]     head_data,
   output logic      [WIDTH-1:0]     data
);

   logic [WIDTH-1:0] data_ff;
   logic [WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.load_new) begin
         data_in = new_data;
      end else if (ctrl.take_head) begin
         data_in = head_data;
      end else if (ctrl.take_nbr) begin
         data_in = nbr_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

### rtl/tcspq_chain.sv
`default_nettype none

module tcspq_chain
   import tcspq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16,
   parameter int CNT_BITS = 5
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire chain_cmd_type        cmd,
   input  wire logic [WIDTH-1:0]     push_data,
   output logic      [WIDTH-1:0]     head_data,
   output logic      [CNT_BITS-1:0]  count
);

   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   logic [CNT_BITS-1:0] last_idx;
   logic [WIDTH-1:0]    cell_q [DEPTH];

   assign last_idx = count_ff - 1'b1;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctrl_type    ctrl;
      logic [WIDTH-1:0] nbr;

      if (i < DEPTH - 1) begin : g_nbr
         assign nbr = cell_q[i+1];
      end else begin : g_end
         assign nbr = '0;
      end

      // Rotate moves the head to the tail slot so a full pass restores order
      assign ctrl.load_new  = cmd.push && (count_ff == CNT_BITS'(i));
      assign ctrl.take_head = cmd.rotate && (last_idx == CNT_BITS'(i));
      assign ctrl.take_nbr  = cmd.pop || (cmd.rotate && (CNT_BITS'(i) < last_idx));

      tcspq_cell #(.WIDTH(WIDTH)) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .new_data  (push_data),
         .nbr_data  (nbr),
         .head_data (cell_q[0]),
         .data      (cell_q[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head_data = cell_q[0];
   assign count     = count_ff;

endmodule

`default_nettype wire

### rtl/two_class_strict_priority_queue.sv
// Add and serve: one result, registered, in the cycle after the word is taken; one word per cycle
// while the result slot is free. List: S_LIST_P, then S_LIST_N register the results, one per cycle
// while the slot is free, priority entries then normal entries (an empty marker for an empty queue);
// input is held off until the last is issued. Each queue is a row of cells; a serve shifts every
// cell toward the head and a list rotates the row one place per result. Sync reset empties both
// queues and sets the threshold to 60; cell contents are not cleared.
`default_nettype none

module two_class_strict_priority_queue
   import tcspq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int TAG_BITS    = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,

   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [FUNC_BITS-1:0]     req_func,
   input  wire logic [EXT_TAG_BITS-1:0]  req_entry_tag,
   input  wire logic [KEY_BITS-1:0]      req_class_key,

   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic      [STATUS_BITS-1:0]   rsp_status,
   output logic                          rsp_queue_sel,
   output logic      [EXT_TAG_BITS-1:0]  rsp_entry_out,
   output logic                          rsp_last,

   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [2:0]               paddr,
   input  wire logic [31:0]              pwdata,
   output logic      [31:0]              prdata,
   output logic                          pready
);

   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(QUEUE_DEPTH);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_LIST_P = 2'd1;
   localparam logic [1:0] S_LIST_N = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [CNT_BITS-1:0]    idx_ff, idx_in;
   logic [KEY_BITS-1:0]    thr_ff, thr_in;

   logic                   out_valid_ff, out_valid_in;
   logic [STATUS_BITS-1:0] out_status_ff, out_status_in;
   logic                   out_sel_ff, out_sel_in;
   logic [TAG_BITS-1:0]    out_tag_ff, out_tag_in;
   logic                   out_last_ff, out_last_in;

   logic [TAG_BITS-1:0]    tag_in;
   logic [TAG_BITS-1:0]    p_head, n_head;
   logic [CNT_BITS-1:0]    p_count, n_count;
   chain_cmd_type          p_cmd, n_cmd;
   logic                   slot_free;
   logic                   accept;
   logic                   csr_write;

   // Fit the tag port to the stored width
   if (TAG_BITS > EXT_TAG_BITS) begin : g_tag_wide
      assign tag_in        = {{(TAG_BITS-EXT_TAG_BITS){1'b0}}, req_entry_tag};
      assign rsp_entry_out = out_tag_ff[EXT_TAG_BITS-1:0];
   end else if (TAG_BITS == EXT_TAG_BITS) begin : g_tag_same
      assign tag_in        = req_entry_tag;
      assign rsp_entry_out = out_tag_ff;
   end else begin : g_tag_narrow
      assign tag_in        = req_entry_tag[TAG_BITS-1:0];
      assign rsp_entry_out = {{(EXT_TAG_BITS-TAG_BITS){1'b0}}, out_tag_ff};
   end

   tcspq_chain #(.DEPTH(QUEUE_DEPTH), .WIDTH(TAG_BITS), .CNT_BITS(CNT_BITS)) u_prio (
      .clock     (clock),
      .reset     (reset),
      .cmd       (p_cmd),
      .push_data (tag_in),
      .head_data (p_head),
      .count     (p_count)
   );

   tcspq_chain #(.DEPTH(QUEUE_DEPTH), .WIDTH(TAG_BITS), .CNT_BITS(CNT_BITS)) u_norm (
      .clock     (clock),
      .reset     (reset),
      .cmd       (n_cmd),
      .push_data (tag_in),
      .head_data (n_head),
      .count     (n_count)
   );

   assign slot_free = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      p_cmd         = '0;
      n_cmd         = '0;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_sel_in    = out_sel_ff;
      out_tag_in    = out_tag_ff;
      out_last_in   = out_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_ADD: begin
                     out_valid_in = 1'b1;
                     out_last_in  = 1'b1;
                     if (req_class_key >= thr_ff) begin
                        out_sel_in = QSEL_PRIORITY;
                        if (p_count == FULL_COUNT) begin
                           out_status_in = ST_FULL;
                           out_tag_in    = '0;
                        end else begin
                           p_cmd.push    = 1'b1;
                           out_status_in = ST_ADDED;
                           out_tag_in    = tag_in;
                        end
                     end else begin
                        out_sel_in = QSEL_NORMAL;
                        if (n_count == FULL_COUNT) begin
                           out_status_in = ST_FULL;
                           out_tag_in    = '0;
                        end else begin
                           n_cmd.push    = 1'b1;
                           out_status_in = ST_ADDED;
                           out_tag_in    = tag_in;
                        end
                     end
                  end
                  FUNC_SERVE: begin
                     out_valid_in = 1'b1;
                     out_last_in  = 1'b1;
                     if (p_count != '0) begin
                        p_cmd.pop     = 1'b1;
                        out_status_in = ST_SERVED;
                        out_sel_in    = QSEL_PRIORITY;
                        out_tag_in    = p_head;
                     end else if (n_count != '0) begin
                        n_cmd.pop     = 1'b1;
                        out_status_in = ST_SERVED;
                        out_sel_in    = QSEL_NORMAL;
                        out_tag_in    = n_head;
                     end else begin
                        out_status_in = ST_NONE;
                        out_sel_in    = QSEL_NORMAL;
                        out_tag_in    = '0;
                     end
                  end
                  FUNC_LIST: begin
                     state_in = S_LIST_P;
                     idx_in   = '0;
                  end
                  default: begin
                     // drop unused code
                  end
               endcase
            end
         end
         S_LIST_P: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_sel_in   = QSEL_PRIORITY;
               out_last_in  = 1'b0;
               if (p_count == '0) begin
                  out_status_in = ST_EMPTY;
                  out_tag_in    = '0;
                  state_in      = S_LIST_N;
                  idx_in        = '0;
               end else begin
                  p_cmd.rotate  = 1'b1;
                  out_status_in = ST_LIST;
                  out_tag_in    = p_head;
                  if (idx_ff == p_count - 1'b1) begin
                     state_in = S_LIST_N;
                     idx_in   = '0;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
            end
         end
         S_LIST_N: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_sel_in   = QSEL_NORMAL;
               if (n_count == '0) begin
                  out_status_in = ST_EMPTY;
                  out_tag_in    = '0;
                  out_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  n_cmd.rotate  = 1'b1;
                  out_status_in = ST_LIST;
                  out_tag_in    = n_head;
                  if (idx_ff == n_count - 1'b1) begin
                     out_last_in = 1'b1;
                     state_in    = S_IDLE;
                     idx_in      = '0;
                  end else begin
                     out_last_in = 1'b0;
                     idx_in      = idx_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Configuration port
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_comb begin
      thr_in = thr_ff;
      if (csr_write && (paddr[2] == REG_THRESHOLD)) begin
         thr_in = pwdata[KEY_BITS-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_THRESHOLD) begin
         prdata = {{(32-KEY_BITS){1'b0}}, thr_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         thr_ff       <= THRESHOLD_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         thr_ff       <= thr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_sel_ff    <= out_sel_in;
      out_tag_ff    <= out_tag_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_queue_sel = out_sel_ff;
   assign rsp_last      = out_last_ff;

endmodule

`default_nettype wire
